FILE: rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types, register map and reset values for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

    // Default width of the tick counter
    localparam int TIMER_BITS_DEF = 18;

    // APB port geometry
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_TRIGGER_TICKS   = 3'd0;
    localparam logic [2:0] REG_TIMEOUT_TICKS   = 3'd1;
    localparam logic [2:0] REG_MAX_VALID_TICKS = 3'd2;
    localparam logic [2:0] REG_PAUSE_TICKS     = 3'd3;
    localparam logic [2:0] REG_DISTANCE_SCALE  = 3'd4;
    localparam logic [2:0] REG_RUN_ENABLE      = 3'd5;

    // Register reset values
    localparam logic [7:0]  RST_TRIGGER_TICKS   = 8'd15;
    localparam logic [15:0] RST_TIMEOUT_TICKS   = 16'd40000;
    localparam logic [15:0] RST_MAX_VALID_TICKS = 16'd38000;
    localparam logic [17:0] RST_PAUSE_TICKS     = 18'd200000;
    localparam logic [17:0] RST_DISTANCE_SCALE  = 18'd112412;
    localparam logic        RST_RUN_ENABLE      = 1'b1;

    // Saturation limit of the 16-bit result fields
    localparam logic [15:0] SAT16 = 16'hFFFF;

    // Measurement phase
    typedef enum logic [1:0] {
        PH_PAUSE,
        PH_TRIG,
        PH_RISE,
        PH_MEAS
    } t_phase;

    // Reported outcome codes
    typedef enum logic [1:0] {
        OC_VALID,
        OC_START_TO,
        OC_END_TO,
        OC_RANGE
    } t_outcome;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  trigger_ticks;
        logic [15:0] timeout_ticks;
        logic [15:0] max_valid_ticks;
        logic [17:0] pause_ticks;
        logic [17:0] distance_scale;
        logic        run_enable;
    } t_cfg;

    // Input word: one tick
    typedef struct packed {
        logic echo_level;
    } t_echo_item;

    // Output word
    typedef struct packed {
        logic        trigger_level;
        logic        report_valid;
        logic [1:0]  outcome;
        logic [15:0] pulse_ticks;
        logic [15:0] distance_centi_cm;
    } t_result_item;

    // Phase controller result, before the distance stage
    typedef struct packed {
        logic        trigger_level;
        logic        report_valid;
        t_outcome    outcome;
        logic [15:0] pulse_ticks;
    } t_meas;

endpackage

`default_nettype wire

FILE: rtl/uer_if.sv
// ----------------------------------------------------------------------------
// uer_if
// Valid/ready stream interfaces for the tick input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface uer_echo_if;
    import uer_pkg::*;
    logic       valid;
    logic       ready;
    t_echo_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface uer_result_if;
    import uer_pkg::*;
    logic         valid;
    logic         ready;
    t_result_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/uer_fsm.sv
// ----------------------------------------------------------------------------
// uer_fsm
// Phase controller: pause, trigger, wait for echo rise, time the echo pulse.
// State moves one step for every accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_fsm
    import uer_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_advance,
    input  wire logic  i_echo_level,
    input  wire t_cfg  i_cfg,
    output t_meas      o_meas
);

    localparam int CMP_W = (TIMER_BITS > 18) ? TIMER_BITS : 18;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_cnt, n_cnt;

    logic [TIMER_BITS-1:0] cnt_inc;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  at_max;
    logic                  trig_done;
    logic                  pause_done;
    logic                  timed_out;
    logic                  width_ok;
    logic [15:0]           pulse_sat;

    // Saturating increment and the compares against it
    assign cnt_inc    = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign cnt_ext    = CMP_W'(cnt_inc);
    assign at_max     = (cnt_inc == CNT_MAX);
    assign trig_done  = (cnt_ext >= CMP_W'(i_cfg.trigger_ticks)) || at_max;
    assign pause_done = (cnt_ext >= CMP_W'(i_cfg.pause_ticks)) || at_max;
    assign timed_out  = (cnt_ext > CMP_W'(i_cfg.timeout_ticks)) || at_max;
    assign width_ok   = (cnt_inc != '0) && (cnt_ext < CMP_W'(i_cfg.max_valid_ticks));
    assign pulse_sat  = (cnt_ext > CMP_W'(SAT16)) ? SAT16 : cnt_inc[15:0];

    // Next state and result of this tick
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        o_meas  = '{trigger_level: 1'b0, report_valid: 1'b0,
                    outcome: OC_VALID, pulse_ticks: 16'd0};
        if (!i_cfg.run_enable) begin
            n_phase = PH_PAUSE;
            n_cnt   = '0;
        end else begin
            case (r_phase)
                PH_TRIG: begin
                    o_meas.trigger_level = 1'b1;
                    n_cnt = cnt_inc;
                    if (trig_done) begin
                        n_phase = PH_RISE;
                        n_cnt   = '0;
                    end
                end
                PH_RISE: begin
                    if (i_echo_level) begin
                        n_phase = PH_MEAS;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = cnt_inc;
                        if (timed_out) begin
                            o_meas.report_valid = 1'b1;
                            o_meas.outcome      = OC_START_TO;
                            n_phase = PH_PAUSE;
                            n_cnt   = '0;
                        end
                    end
                end
                PH_MEAS: begin
                    n_cnt = cnt_inc;
                    if (!i_echo_level) begin
                        // falling edge closes the pulse
                        o_meas.report_valid = 1'b1;
                        o_meas.pulse_ticks  = pulse_sat;
                        o_meas.outcome      = width_ok ? OC_VALID : OC_RANGE;
                        n_phase = PH_PAUSE;
                        n_cnt   = '0;
                    end else if (timed_out) begin
                        o_meas.report_valid = 1'b1;
                        o_meas.outcome      = OC_END_TO;
                        o_meas.pulse_ticks  = pulse_sat;
                        n_phase = PH_PAUSE;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    // pause between measurements
                    n_cnt = cnt_inc;
                    if (pause_done) begin
                        n_phase = PH_TRIG;
                        n_cnt   = '0;
                    end
                end
            endcase
        end
    end

    // Phase and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PAUSE;
            r_cnt   <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/uer_dist.sv
// ----------------------------------------------------------------------------
// uer_dist
// Distance conversion: pulse width times Q16 reciprocal, saturated to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_dist
    import uer_pkg::*;
(
    input  wire t_meas        i_meas,
    input  wire logic [17:0]  i_scale,
    output t_result_item      o_result
);

    logic [33:0] product;
    logic [17:0] scaled;
    logic [15:0] dist_sat;
    logic        is_valid;

    // 16 x 18 multiply, keep the integer part
    assign product  = 34'(i_meas.pulse_ticks) * 34'(i_scale);
    assign scaled   = product[33:16];
    assign dist_sat = (scaled > 18'(SAT16)) ? SAT16 : scaled[15:0];
    assign is_valid = i_meas.report_valid && (i_meas.outcome == OC_VALID);

    always_comb begin
        o_result.trigger_level     = i_meas.trigger_level;
        o_result.report_valid      = i_meas.report_valid;
        o_result.outcome           = i_meas.outcome;
        o_result.pulse_ticks       = i_meas.pulse_ticks;
        o_result.distance_centi_cm = is_valid ? dist_sat : 16'd0;
    end

endmodule

`default_nettype wire

FILE: rtl/ultrasonic_echo_ranger.sv
// Pipeline: an accepted tick's phase controller result is captured in the stage 1
//   register, then passes the distance multiply into the output register.
// Throughput: one tick per cycle while the result output is not stalled.
// Reset: synchronous, active low; registers return to their defaults, phase to
//   pause with the tick counter at zero, and both pipeline stages empty.
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Ultrasonic range controller: trigger pulse, echo timing, outcome and distance
// per tick, with an APB register port.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    uer_echo_if.sink               i_echo,
    uer_result_if.source           o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    t_cfg         r_cfg;
    logic [2:0]   reg_idx;
    logic         cfg_wr;

    t_meas        fsm_meas;
    t_meas        r_s1;
    logic         r_s1_vld;
    t_result_item dist_word;
    t_result_item r_out;
    logic         r_out_vld;

    logic         out_free;
    logic         s1_adv;
    logic         in_acc;

    // APB register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks   <= RST_TRIGGER_TICKS;
            r_cfg.timeout_ticks   <= RST_TIMEOUT_TICKS;
            r_cfg.max_valid_ticks <= RST_MAX_VALID_TICKS;
            r_cfg.pause_ticks     <= RST_PAUSE_TICKS;
            r_cfg.distance_scale  <= RST_DISTANCE_SCALE;
            r_cfg.run_enable      <= RST_RUN_ENABLE;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TRIGGER_TICKS:   r_cfg.trigger_ticks   <= pwdata[7:0];
                REG_TIMEOUT_TICKS:   r_cfg.timeout_ticks   <= pwdata[15:0];
                REG_MAX_VALID_TICKS: r_cfg.max_valid_ticks <= pwdata[15:0];
                REG_PAUSE_TICKS:     r_cfg.pause_ticks     <= pwdata[17:0];
                REG_DISTANCE_SCALE:  r_cfg.distance_scale  <= pwdata[17:0];
                REG_RUN_ENABLE:      r_cfg.run_enable      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            REG_TRIGGER_TICKS:   prdata = APB_DW'(r_cfg.trigger_ticks);
            REG_TIMEOUT_TICKS:   prdata = APB_DW'(r_cfg.timeout_ticks);
            REG_MAX_VALID_TICKS: prdata = APB_DW'(r_cfg.max_valid_ticks);
            REG_PAUSE_TICKS:     prdata = APB_DW'(r_cfg.pause_ticks);
            REG_DISTANCE_SCALE:  prdata = APB_DW'(r_cfg.distance_scale);
            REG_RUN_ENABLE:      prdata = APB_DW'(r_cfg.run_enable);
            default:             prdata = '0;
        endcase
    end

    // Pipeline flow: output register, then stage 1
    assign out_free     = !r_out_vld || o_result.ready;
    assign s1_adv       = r_s1_vld && out_free;
    assign i_echo.ready = !r_s1_vld || out_free;
    assign in_acc       = i_echo.valid && i_echo.ready;

    // Phase controller, stepped once per accepted tick
    uer_fsm #(
        .TIMER_BITS (TIMER_BITS)
    ) u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (in_acc),
        .i_echo_level (i_echo.data.echo_level),
        .i_cfg        (r_cfg),
        .o_meas       (fsm_meas)
    );

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= fsm_meas;
        end
    end

    // Distance stage into the output register
    uer_dist u_dist (
        .i_meas   (r_s1),
        .i_scale  (r_cfg.distance_scale),
        .o_result (dist_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= dist_word;
        end
    end

    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks on the result stream of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_checker
    import uer_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_out_valid,
    input wire logic         i_out_ready,
    input wire t_result_item i_out_data
);

    // A word without a report carries no outcome, width or distance
    a_quiet_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.report_valid) |->
        (i_out_data.outcome == OC_VALID && i_out_data.pulse_ticks == 16'd0 &&
         i_out_data.distance_centi_cm == 16'd0))
        else $error("uer: unreported word carries data");

    // Distance only for a valid outcome
    a_dist_valid_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.distance_centi_cm != 16'd0) |->
        (i_out_data.report_valid && i_out_data.outcome == OC_VALID))
        else $error("uer: distance outside a valid outcome");

    // A start timeout never saw a rise, so no width
    a_start_to_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.report_valid && i_out_data.outcome == OC_START_TO)
        |-> (i_out_data.pulse_ticks == 16'd0))
        else $error("uer: start timeout with nonzero width");

    // Trigger ticks never report
    a_trig_no_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.trigger_level && i_out_data.report_valid))
        else $error("uer: report during trigger");

    // A stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("uer: stalled output word changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ultrasonic echo ranger. Every accepted echo tick
// is run through a cycle-level predictor of the trigger/wait/measure/pause
// sequencer, and every result word is compared field by field with the
// prediction, under random stalls on both streams and APB register changes.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import uer_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam logic [TIMER_BITS_DEF-1:0] COUNT_MAX = '1;
    localparam logic [2:0] REG_LIST [6] = '{REG_TRIGGER_TICKS, REG_TIMEOUT_TICKS,
        REG_MAX_VALID_TICKS, REG_PAUSE_TICKS, REG_DISTANCE_SCALE, REG_RUN_ENABLE};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    uer_echo_if   echo_if ();
    uer_result_if res_if ();

    ultrasonic_echo_ranger DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_echo   (echo_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state and register shadow
    t_cfg                      ranger_cfg = '{RST_TRIGGER_TICKS, RST_TIMEOUT_TICKS,
        RST_MAX_VALID_TICKS, RST_PAUSE_TICKS, RST_DISTANCE_SCALE, RST_RUN_ENABLE};
    t_phase                    ranger_phase = PH_PAUSE;
    logic [TIMER_BITS_DEF-1:0] ranger_count = '0;
    t_result_item              pending_words [$];

    int     n_errors = 0;
    int     n_ticks = 0;
    int     n_reports = 0;
    int     outcome_hits [4] = '{0, 0, 0, 0};
    bit     idle_en = 1'b0;
    int     noise_pct = 0;
    int     sink_hold = 0;
    int     sink_gap = 0;
    longint cycle_count = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [15:0] sat16(input longint v);
        return (v > 65535) ? SAT16 : v[15:0];
    endfunction

    // strict: counter must pass the target; a saturated counter always hits
    function automatic bit hit_target(input longint tgt, input bit strict);
        if (ranger_count == COUNT_MAX) return 1'b1;
        return strict ? (ranger_count > tgt) : (ranger_count >= tgt);
    endfunction

    task automatic count_tick();
        if (ranger_count != COUNT_MAX) ranger_count++;
    endtask

    task automatic restart_pause();
        ranger_phase = PH_PAUSE;
        ranger_count = '0;
    endtask

    task automatic predict_tick(input bit echo);
        t_result_item w;
        longint       width;
        w = '0;
        if (!ranger_cfg.run_enable) begin
            restart_pause();
        end else begin
            case (ranger_phase)
                PH_TRIG: begin
                    w.trigger_level = 1'b1;
                    count_tick();
                    if (hit_target(ranger_cfg.trigger_ticks, 1'b0)) begin
                        ranger_phase = PH_RISE;
                        ranger_count = '0;
                    end
                end
                PH_RISE: begin
                    if (echo) begin
                        ranger_phase = PH_MEAS;
                        ranger_count = '0;
                    end else begin
                        count_tick();
                        if (hit_target(ranger_cfg.timeout_ticks, 1'b1)) begin
                            w.report_valid = 1'b1;
                            w.outcome = OC_START_TO;
                            restart_pause();
                        end
                    end
                end
                PH_MEAS: begin
                    count_tick();
                    width = ranger_count;
                    if (!echo) begin
                        // falling edge closes the pulse
                        w.report_valid = 1'b1;
                        w.pulse_ticks = sat16(width);
                        if (width > 0 && width < ranger_cfg.max_valid_ticks) begin
                            w.outcome = OC_VALID;
                            w.distance_centi_cm =
                                sat16((width * longint'(ranger_cfg.distance_scale)) >> 16);
                        end else begin
                            w.outcome = OC_RANGE;
                        end
                        restart_pause();
                    end else if (hit_target(ranger_cfg.timeout_ticks, 1'b1)) begin
                        w.report_valid = 1'b1;
                        w.outcome = OC_END_TO;
                        w.pulse_ticks = sat16(width);
                        restart_pause();
                    end
                end
                default: begin
                    ranger_phase = PH_PAUSE;
                    count_tick();
                    if (hit_target(ranger_cfg.pause_ticks, 1'b0)) begin
                        ranger_phase = PH_TRIG;
                        ranger_count = '0;
                    end
                end
            endcase
        end
        if (w.report_valid) begin
            n_reports++;
            outcome_hits[w.outcome]++;
        end
        pending_words.push_back(w);
    endtask

    // ------------------------------------------------------------------
    // Echo shaping: rise after 'delay' waiting ticks, fall at pulse 'width'
    // ------------------------------------------------------------------
    function automatic bit echo_for(input int delay, input int width);
        if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
            return 1'($urandom_range(0, 1));
        case (ranger_phase)
            PH_RISE: return int'(ranger_count) >= delay;
            PH_MEAS: return int'(ranger_count) + 1 < width;
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tick sender: one word per call, optional gap before it
    // ------------------------------------------------------------------
    task automatic send_tick(input bit echo);
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            echo_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        echo_if.valid <= 1'b1;
        echo_if.data.echo_level <= echo;
        @(posedge i_clk);
        while (!echo_if.ready) @(posedge i_clk);
        predict_tick(echo);
        n_ticks++;
    endtask

    // Run ticks until the next outcome is reported
    task automatic measure(input int delay, input int width);
        int start_reports;
        start_reports = n_reports;
        while (n_reports == start_reports) send_tick(echo_for(delay, width));
    endtask

    // Drain: stop offering ticks and wait for every predicted word
    task automatic settle();
        @(negedge i_clk);
        echo_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------
    task automatic apb_access(input logic [2:0] idx, input bit wr,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] unused;
        apb_access(idx, 1'b1, val, unused);
        case (idx)
            REG_TRIGGER_TICKS:   ranger_cfg.trigger_ticks   = val[7:0];
            REG_TIMEOUT_TICKS:   ranger_cfg.timeout_ticks   = val[15:0];
            REG_MAX_VALID_TICKS: ranger_cfg.max_valid_ticks = val[15:0];
            REG_PAUSE_TICKS:     ranger_cfg.pause_ticks     = val[17:0];
            REG_DISTANCE_SCALE:  ranger_cfg.distance_scale  = val[17:0];
            REG_RUN_ENABLE:      ranger_cfg.run_enable      = val[0];
            default: ;
        endcase
    endtask

    task automatic read_check(input logic [2:0] idx);
        logic [APB_DW-1:0] got;
        logic [APB_DW-1:0] want;
        apb_access(idx, 1'b0, '0, got);
        case (idx)
            REG_TRIGGER_TICKS:   want = APB_DW'(ranger_cfg.trigger_ticks);
            REG_TIMEOUT_TICKS:   want = APB_DW'(ranger_cfg.timeout_ticks);
            REG_MAX_VALID_TICKS: want = APB_DW'(ranger_cfg.max_valid_ticks);
            REG_PAUSE_TICKS:     want = APB_DW'(ranger_cfg.pause_ticks);
            REG_DISTANCE_SCALE:  want = APB_DW'(ranger_cfg.distance_scale);
            default:             want = APB_DW'(ranger_cfg.run_enable);
        endcase
        if (got !== want) begin
            $error("prdata mismatch at register %0d: expected %0h, got %0h", idx, want, got);
            n_errors++;
        end
    endtask

    // Full timing setup with the ranger running
    task automatic set_timing(input int trig, input int tmo, input int maxv,
                              input int pause, input int scale);
        settle();
        write_reg(REG_TRIGGER_TICKS, trig);
        write_reg(REG_TIMEOUT_TICKS, tmo);
        write_reg(REG_MAX_VALID_TICKS, maxv);
        write_reg(REG_PAUSE_TICKS, pause);
        write_reg(REG_DISTANCE_SCALE, scale);
        write_reg(REG_RUN_ENABLE, 1);
    endtask

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts plus a requested long hold
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            res_if.ready <= 1'b0;
            sink_hold--;
        end else if (sink_gap > 0) begin
            res_if.ready <= 1'b0;
            sink_gap--;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            res_if.ready <= 1'b0;
            sink_gap = $urandom_range(1, 12) - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result_item want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_words.size() == 0) begin
                $error("result word with no expectation pending");
                n_errors++;
            end else begin
                want = pending_words.pop_front();
                check_field("trigger_level", want.trigger_level, res_if.data.trigger_level);
                check_field("report_valid", want.report_valid, res_if.data.report_valid);
                check_field("outcome", want.outcome, res_if.data.outcome);
                check_field("pulse_ticks", want.pulse_ticks, res_if.data.pulse_ticks);
                check_field("distance_centi_cm", want.distance_centi_cm,
                            res_if.data.distance_centi_cm);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values, then all-ones and all-zeros read back
    task automatic test_register_map();
        foreach (REG_LIST[i]) read_check(REG_LIST[i]);
        foreach (REG_LIST[i]) write_reg(REG_LIST[i], '1);
        foreach (REG_LIST[i]) read_check(REG_LIST[i]);
        foreach (REG_LIST[i]) write_reg(REG_LIST[i], '0);
        foreach (REG_LIST[i]) read_check(REG_LIST[i]);
    endtask

    // Valid pulses, shortest pulse, range edge, zero scale
    task automatic test_valid_echo();
        set_timing(2, 100, 50, 3, RST_DISTANCE_SCALE);
        measure(3, 10);
        measure(0, 1);
        measure(5, 49);
        measure(5, 50);
        settle();
        write_reg(REG_DISTANCE_SCALE, 0);
        measure(1, 20);
    endtask

    // Echo never rises, and rises on the last allowed tick
    task automatic test_start_timeout();
        set_timing(2, 100, 50, 3, RST_DISTANCE_SCALE);
        measure(101, 5);
        measure(100, 3);
    endtask

    // Echo held past the timeout, and falling right at it
    task automatic test_end_timeout();
        set_timing(2, 100, 200, 3, RST_DISTANCE_SCALE);
        measure(2, 102);
        measure(2, 101);
    endtask

    // Shortest and longest trigger pulse
    task automatic test_trigger_lengths();
        set_timing(0, 30, 20, 0, RST_DISTANCE_SCALE);
        measure(1, 4);
        set_timing(255, 30, 20, 1, RST_DISTANCE_SCALE);
        measure(3, 5);
    endtask

    // Zero timeout and zero range limit
    task automatic test_zero_limits();
        set_timing(1, 0, 0, 0, RST_DISTANCE_SCALE);
        measure(0, 1);
        measure(1, 1);
        measure(0, 5);
    endtask

    // Disabling mid-pulse drops the measurement without a report
    task automatic test_disable();
        int k;
        set_timing(2, 50, 40, 2, RST_DISTANCE_SCALE);
        while (ranger_phase != PH_MEAS) send_tick(echo_for(1, 1000));
        for (k = 0; k < 3; k++) send_tick(1'b1);
        settle();
        write_reg(REG_RUN_ENABLE, 0);
        for (k = 0; k < 20; k++) send_tick(1'($urandom_range(0, 1)));
        settle();
        write_reg(REG_RUN_ENABLE, 1);
        measure(4, 8);
    endtask

    // Receiver holds off while ticks keep coming, so the input stalls
    task automatic test_backpressure();
        int k;
        idle_en = 1'b1;
        set_timing(1, 40, 30, 2, RST_DISTANCE_SCALE);
        sink_hold = 500;
        for (k = 0; k < 8; k++) measure($urandom_range(0, 20), $urandom_range(1, 35));
    endtask

    // One random register setting, then measurements for 'budget' ticks
    task automatic random_phase(input int budget);
        int stop_at;
        int tmo;
        int maxv;
        int delay;
        int width;
        int start_reports;
        tmo  = $urandom_range(0, 60);
        maxv = $urandom_range(0, 70);
        set_timing(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 5), tmo, maxv,
                   $urandom_range(0, 12), $urandom_range(0, 262143));
        if ($urandom_range(0, 9) == 0) write_reg(REG_RUN_ENABLE, 0);
        stop_at = n_ticks + budget;
        while (n_ticks < stop_at) begin
            if (!ranger_cfg.run_enable) begin
                send_tick(1'($urandom_range(0, 1)));
            end else begin
                // mostly clean echoes, some noisy or broken ones
                delay = $urandom_range(0, tmo + 3);
                width = $urandom_range(1, ((tmo > maxv) ? tmo : maxv) + 3);
                noise_pct = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40) : 0;
                start_reports = n_reports;
                while (n_reports == start_reports && n_ticks < stop_at)
                    send_tick(echo_for(delay, width));
            end
        end
        noise_pct = 0;
    endtask

    task automatic test_random();
        int first_tick;
        first_tick = n_ticks;
        idle_en = 1'b1;
        while (n_ticks - first_tick < 300)
            random_phase(150);
        // closing stretch at full rate
        idle_en = 1'b0;
        random_phase(100);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        echo_if.valid = 1'b0;
        echo_if.data  = '0;
        res_if.ready  = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_map();
        test_valid_echo();
        test_start_timeout();
        test_end_timeout();
        test_trigger_lengths();
        test_zero_limits();
        test_disable();
        test_backpressure();
        test_random();
        settle();

        $display("Ran %0d echo ticks with %0d reported measurements", n_ticks, n_reports);
        $display("Outcomes: valid %0d, start timeout %0d, end timeout %0d, out of range %0d",
                 outcome_hits[OC_VALID], outcome_hits[OC_START_TO],
                 outcome_hits[OC_END_TO], outcome_hits[OC_RANGE]);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/uer_pkg.sv
rtl/uer_if.sv
rtl/uer_fsm.sv
rtl/uer_dist.sv
rtl/ultrasonic_echo_ranger.sv
rtl/uer_checker.sv
dv/tb_top.sv
